// File: design/rbmr_pkg.sv
// rbmr_pkg: shared constants, sine table and fixed-point helpers for the
// rotated bitmap led matrix renderer; no dependencies
`default_nettype none

package rbmr_pkg;

    localparam int WIDTH          = 5;
    localparam int HEIGHT         = 10;
    localparam int TRIG_FRAC_BITS = 14;
    localparam int TOTAL          = WIDTH * HEIGHT;
    localparam int MASK_BITS      = TOTAL;
    localparam logic [MASK_BITS-1:0] MASK_RESET = MASK_BITS'(64'd256505281615153);

    localparam int X_W      = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int P_W      = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
    localparam int IDX_W    = 6;
    localparam int MIDX_W   = $clog2(MASK_BITS);
    localparam int COORD_W  = 6;
    localparam int TRIG_W   = TRIG_FRAC_BITS + 2;
    localparam int PROD_W   = COORD_W + TRIG_W;
    localparam int N_W      = PROD_W + 2;
    localparam int DEG_W    = 9;
    localparam int COLOR_W  = 8;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 32;

    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(TOTAL - 1);
    localparam logic [DEG_W-1:0] ANGLE_WRAP  = DEG_W'(512 - 360);

    localparam int SCALE_UP = (TRIG_FRAC_BITS >= 14) ? TRIG_FRAC_BITS - 14 : 0;
    localparam int SCALE_DN = (TRIG_FRAC_BITS < 14) ? 14 - TRIG_FRAC_BITS : 0;
    localparam logic [31:0] SCALE_RND = (SCALE_DN > 0) ? 32'(1 << (SCALE_DN - 1)) : 32'd0;

    localparam logic signed [N_W-1:0] HALF  = N_W'(2 ** TRIG_FRAC_BITS);
    localparam logic signed [N_W-1:0] OFF_X = N_W'((WIDTH - 1) * (2 ** TRIG_FRAC_BITS));
    localparam logic signed [N_W-1:0] OFF_Y = N_W'((HEIGHT - 1) * (2 ** TRIG_FRAC_BITS));

    localparam logic [14:0] QUARTER_SINE [0:90] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
        15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
        15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
        15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
        15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
        15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
        15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
        15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
        15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
        15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
        15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
        15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
        15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
        15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
        15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
        15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
        15'd16384
    };

    // deg in 0..359
    function automatic logic signed [TRIG_W-1:0] sine_fixed(input logic [DEG_W-1:0] deg);
        logic [DEG_W-1:0] folded;
        logic             neg;
        logic [31:0]      mag;
        folded = deg;
        neg    = 1'b0;
        if (deg < DEG_W'(90)) begin
            folded = deg;
        end else if (deg < DEG_W'(180)) begin
            folded = DEG_W'(180) - deg;
        end else if (deg < DEG_W'(270)) begin
            folded = deg - DEG_W'(180);
            neg    = 1'b1;
        end else begin
            folded = DEG_W'(360) - deg;
            neg    = 1'b1;
        end
        mag = 32'(QUARTER_SINE[folded[6:0]]);
        mag = ((mag << SCALE_UP) + SCALE_RND) >> SCALE_DN;
        return neg ? -TRIG_W'(mag) : TRIG_W'(mag);
    endfunction

    // divide by 2^(frac+1), round to nearest, ties away from zero
    function automatic logic signed [N_W-1:0] round_coord(input logic signed [N_W-1:0] n);
        logic [N_W-1:0] mag;
        mag = n[N_W-1] ? N_W'(-n) : N_W'(n);
        mag = (mag + N_W'(HALF)) >> (TRIG_FRAC_BITS + 1);
        return n[N_W-1] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

`default_nettype wire

// File: design/rotated_bitmap_led_matrix_render.sv
// rotated_bitmap_led_matrix_render: frame request sequencer and four-stage
// led pipeline (trig, multiply, round, bitmap lookup); uses rbmr_pkg
`default_nettype none

//  channel  | direction | contents
//  s_*      | in        | frame request: angle and color
//  m_*      | out       | one item per led, chain order, tlast on the final led
//  cfg_*    | in        | shape_mask write
//
// a request yields 50 led items, one per cycle unless m_tready stalls; the led sequencer sets the rate
// a new request is taken in the cycle the previous one issues its last led
// an issued led is registered through pipeline stages 1 to 4 before it reaches m_tvalid
// a waiting m_ item with m_tready low freezes the whole pipeline; nothing is dropped
// aresetn clears the pipeline valids and the sequencer and reloads the default shape_mask

module rotated_bitmap_led_matrix_render (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    input  wire                                    s_tvalid,
    output logic                                   s_tready,
    // angle[8:0], red[16:9], green[24:17], blue[32:25], zero pad
    input  wire  [rbmr_pkg::S_DATA_W-1:0]          s_tdata,
    output logic                                   m_tvalid,
    input  wire                                    m_tready,
    // led_index[5:0], green_out[13:6], red_out[21:14], blue_out[29:22], zero pad
    output logic [rbmr_pkg::M_DATA_W-1:0]          m_tdata,
    // last_led
    output logic                                   m_tlast,
    input  wire                                    cfg_wr_en,
    input  wire  [rbmr_pkg::MASK_BITS-1:0]         cfg_wr_data
);

    localparam int CW = rbmr_pkg::COLOR_W;

    logic [rbmr_pkg::MASK_BITS-1:0] mask_reg;

    // request and sequencer
    logic                          busy_reg;
    logic [rbmr_pkg::DEG_W-1:0]    deg_reg;
    logic [CW-1:0]                 red_reg, green_reg, blue_reg;
    logic [rbmr_pkg::X_W-1:0]      x_reg;
    logic [rbmr_pkg::P_W-1:0]      p_reg;
    logic [rbmr_pkg::IDX_W-1:0]    idx_reg;

    // stage 1
    logic                                 v1_reg, last1_reg;
    logic [rbmr_pkg::IDX_W-1:0]           idx1_reg;
    logic signed [rbmr_pkg::COORD_W-1:0]  dx1_reg, dy1_reg;
    logic signed [rbmr_pkg::TRIG_W-1:0]   s1_reg, c1_reg;
    logic [CW-1:0]                        r1_reg, g1_reg, b1_reg;
    // stage 2
    logic                                 v2_reg, last2_reg;
    logic [rbmr_pkg::IDX_W-1:0]           idx2_reg;
    logic signed [rbmr_pkg::PROD_W-1:0]   pxc2_reg, pys2_reg, pyc2_reg, pxs2_reg;
    logic [CW-1:0]                        r2_reg, g2_reg, b2_reg;
    // stage 3
    logic                                 v3_reg, last3_reg, hit3_reg;
    logic [rbmr_pkg::IDX_W-1:0]           idx3_reg;
    logic [rbmr_pkg::MIDX_W-1:0]          bit3_reg;
    logic [CW-1:0]                        r3_reg, g3_reg, b3_reg;
    // stage 4 (output)
    logic                                 v4_reg, last4_reg;
    logic [rbmr_pkg::M_DATA_W-1:0]        data4_reg;

    logic                                 adv;
    logic                                 s_accept;
    logic                                 seq_last;
    logic [rbmr_pkg::DEG_W-1:0]           deg_next;
    logic [rbmr_pkg::DEG_W-1:0]           cos_deg;
    logic [rbmr_pkg::P_W-1:0]             y_cur;
    logic signed [rbmr_pkg::COORD_W-1:0]  dx_next, dy_next;
    logic signed [rbmr_pkg::N_W-1:0]      nx, ny, sx, sy;
    logic                                 hit_next;
    logic [rbmr_pkg::MIDX_W-1:0]          bit_next;
    logic                                 lit;

    assign adv      = !v4_reg || m_tready;
    assign seq_last = (idx_reg == rbmr_pkg::LAST_IDX);
    assign s_tready = !busy_reg || (adv && seq_last);
    assign s_accept = s_tvalid && s_tready;

    // wrap negative angles by adding 360
    assign deg_next = s_tdata[8] ? (s_tdata[8:0] - rbmr_pkg::ANGLE_WRAP) : s_tdata[8:0];
    assign cos_deg  = (deg_reg >= rbmr_pkg::DEG_W'(270)) ? (deg_reg - rbmr_pkg::DEG_W'(270))
                                                         : (deg_reg + rbmr_pkg::DEG_W'(90));

    // serpentine: odd columns run in reverse, from row HEIGHT-1 down to row 0
    assign y_cur   = x_reg[0] ? (rbmr_pkg::P_W'(rbmr_pkg::HEIGHT - 1) - p_reg) : p_reg;
    assign dx_next = $signed(rbmr_pkg::COORD_W'({x_reg, 1'b0}))
                   - $signed(rbmr_pkg::COORD_W'(rbmr_pkg::WIDTH - 1));
    assign dy_next = $signed(rbmr_pkg::COORD_W'({y_cur, 1'b0}))
                   - $signed(rbmr_pkg::COORD_W'(rbmr_pkg::HEIGHT - 1));

    always_comb begin
        nx = rbmr_pkg::N_W'(pxc2_reg) + rbmr_pkg::N_W'(pys2_reg) + rbmr_pkg::OFF_X;
        ny = rbmr_pkg::N_W'(pyc2_reg) - rbmr_pkg::N_W'(pxs2_reg) + rbmr_pkg::OFF_Y;
        sx = rbmr_pkg::round_coord(nx);
        sy = rbmr_pkg::round_coord(ny);
        hit_next = (sx >= 0) && (sx < rbmr_pkg::N_W'(rbmr_pkg::WIDTH))
                && (sy >= 0) && (sy < rbmr_pkg::N_W'(rbmr_pkg::HEIGHT));
        bit_next = rbmr_pkg::MIDX_W'(rbmr_pkg::MIDX_W'(sy[rbmr_pkg::P_W-1:0])
                 * rbmr_pkg::MIDX_W'(rbmr_pkg::WIDTH))
                 + rbmr_pkg::MIDX_W'(sx[rbmr_pkg::X_W-1:0]);
    end

    assign lit = hit3_reg && mask_reg[bit3_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= rbmr_pkg::MASK_RESET;
        end else if (cfg_wr_en) begin
            mask_reg <= cfg_wr_data;
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            x_reg    <= '0;
            p_reg    <= '0;
            idx_reg  <= '0;
        end else begin
            if (busy_reg && adv) begin
                idx_reg <= idx_reg + 1'b1;
                if (p_reg == rbmr_pkg::P_W'(rbmr_pkg::HEIGHT - 1)) begin
                    p_reg <= '0;
                    x_reg <= x_reg + 1'b1;
                end else begin
                    p_reg <= p_reg + 1'b1;
                end
                if (seq_last) begin
                    busy_reg <= 1'b0;
                end
            end
            if (s_accept) begin
                busy_reg <= 1'b1;
                x_reg    <= '0;
                p_reg    <= '0;
                idx_reg  <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            deg_reg   <= deg_next;
            red_reg   <= s_tdata[16:9];
            green_reg <= s_tdata[24:17];
            blue_reg  <= s_tdata[32:25];
        end
    end

    // pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= busy_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            idx1_reg  <= idx_reg;
            last1_reg <= seq_last;
            dx1_reg   <= dx_next;
            dy1_reg   <= dy_next;
            s1_reg    <= rbmr_pkg::sine_fixed(deg_reg);
            c1_reg    <= rbmr_pkg::sine_fixed(cos_deg);
            r1_reg    <= red_reg;
            g1_reg    <= green_reg;
            b1_reg    <= blue_reg;

            idx2_reg  <= idx1_reg;
            last2_reg <= last1_reg;
            pxc2_reg  <= rbmr_pkg::PROD_W'(dx1_reg) * rbmr_pkg::PROD_W'(c1_reg);
            pys2_reg  <= rbmr_pkg::PROD_W'(dy1_reg) * rbmr_pkg::PROD_W'(s1_reg);
            pyc2_reg  <= rbmr_pkg::PROD_W'(dy1_reg) * rbmr_pkg::PROD_W'(c1_reg);
            pxs2_reg  <= rbmr_pkg::PROD_W'(dx1_reg) * rbmr_pkg::PROD_W'(s1_reg);
            r2_reg    <= r1_reg;
            g2_reg    <= g1_reg;
            b2_reg    <= b1_reg;

            idx3_reg  <= idx2_reg;
            last3_reg <= last2_reg;
            hit3_reg  <= hit_next;
            bit3_reg  <= bit_next;
            r3_reg    <= r2_reg;
            g3_reg    <= g2_reg;
            b3_reg    <= b2_reg;

            last4_reg <= last3_reg;
            data4_reg <= {2'b00,
                          lit ? b3_reg : 8'h00,
                          lit ? r3_reg : 8'h00,
                          lit ? g3_reg : 8'h00,
                          idx3_reg};
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = data4_reg;
    assign m_tlast  = last4_reg;

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[5:0] == rbmr_pkg::LAST_IDX))
        else $error("tlast on an led other than the final one");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && busy_reg) |-> (seq_last && adv))
        else $error("request taken while the previous frame is still issuing");

    a_busy_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(busy_reg) |-> ($past(seq_last) && $past(adv)))
        else $error("sequencer stopped before the final led");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(v3_reg) && $stable(idx3_reg)))
        else $error("pipeline moved during an output stall");

endmodule

`default_nettype wire

// File: tb/rotated_bitmap_led_matrix_render_tb.sv
// rotated_bitmap_led_matrix_render_tb: drives frame requests and shape_mask writes,
// predicts the 50 led colors of each frame and checks every m_ item in order
// depends on rbmr_pkg and rotated_bitmap_led_matrix_render
`timescale 1ns / 100ps

module rotated_bitmap_led_matrix_render_tb;

    localparam int COLS = 5;
    localparam int ROWS = 10;
    localparam int LEDS = COLS * ROWS;
    localparam int ONE  = 1 << 14;

    localparam logic [49:0] SHAPE_FULL  = '1;
    localparam logic [49:0] SHAPE_EMPTY = '0;
    localparam logic [49:0] SHAPE_CHECK = 50'h2AAAAAAAAAAAA;

    localparam int SINE_Q14 [0:90] = '{
        0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
        2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
        5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
        8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
        16384
    };

    typedef enum logic [1:0] {BY_MODEL, ALL_LIT, ALL_DARK} chk_t;

    typedef struct packed {
        logic [5:0] idx;
        logic [7:0] g;
        logic [7:0] r;
        logic [7:0] b;
        logic       last;
    } led_t;

    typedef struct packed {
        chk_t              chk;
        logic              wr;
        logic [49:0]       mask;
        logic signed [8:0] angle;
        logic [7:0]        r;
        logic [7:0]        g;
        logic [7:0]        b;
    } row_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_wr_en   = 1'b0;
    logic [49:0] cfg_wr_data = '0;

    led_t        led_q [$];
    logic [49:0] shape_now = rbmr_pkg::MASK_RESET;
    int          errors    = 0;
    int          sent      = 0;

    row_t plan [0:21] = '{
        '{BY_MODEL, 1'b0, SHAPE_EMPTY, 0,    8'hFF, 8'h00, 8'h80},
        '{BY_MODEL, 1'b0, SHAPE_EMPTY, 180,  8'h12, 8'h34, 8'h56},
        '{BY_MODEL, 1'b0, SHAPE_EMPTY, -180, 8'hAA, 8'h55, 8'hFF},
        '{BY_MODEL, 1'b0, SHAPE_EMPTY, 90,   8'h01, 8'h80, 8'hFE},
        '{BY_MODEL, 1'b0, SHAPE_EMPTY, -90,  8'h7F, 8'hFF, 8'h00},
        '{BY_MODEL, 1'b0, SHAPE_EMPTY, 45,   8'hFF, 8'hFF, 8'hFF},
        '{BY_MODEL, 1'b0, SHAPE_EMPTY, -1,   8'h00, 8'h01, 8'h02},
        '{BY_MODEL, 1'b0, SHAPE_EMPTY, 255,  8'h80, 8'h40, 8'h20},
        '{BY_MODEL, 1'b0, SHAPE_EMPTY, -256, 8'h0F, 8'hF0, 8'h3C},
        '{BY_MODEL, 1'b0, SHAPE_EMPTY, 200,  8'hC3, 8'h3C, 8'h99},
        '{ALL_LIT,  1'b1, SHAPE_FULL,  0,    8'hFF, 8'hFF, 8'hFF},
        '{ALL_LIT,  1'b0, SHAPE_FULL,  180,  8'h11, 8'h22, 8'h33},
        '{ALL_LIT,  1'b0, SHAPE_FULL,  -180, 8'h00, 8'h00, 8'h00},
        '{BY_MODEL, 1'b0, SHAPE_FULL,  30,   8'h5A, 8'hA5, 8'h66},
        '{BY_MODEL, 1'b0, SHAPE_FULL,  -200, 8'h44, 8'h88, 8'hCC},
        '{ALL_DARK, 1'b1, SHAPE_EMPTY, 37,   8'hFF, 8'hFF, 8'hFF},
        '{ALL_DARK, 1'b0, SHAPE_EMPTY, -256, 8'hFF, 8'hFF, 8'hFF},
        '{BY_MODEL, 1'b1, SHAPE_CHECK, 0,    8'h21, 8'h43, 8'h65},
        '{BY_MODEL, 1'b0, SHAPE_CHECK, -135, 8'h87, 8'hA9, 8'hCB},
        '{BY_MODEL, 1'b1, 50'h1,       0,    8'hFF, 8'h00, 8'hFF},
        '{BY_MODEL, 1'b1, 50'h2000000000000, 180, 8'h00, 8'hFF, 8'h00},
        '{BY_MODEL, 1'b1, rbmr_pkg::MASK_RESET, 179, 8'hDE, 8'hAD, 8'hBE}
    };

    rotated_bitmap_led_matrix_render i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #8000000;
        $display("rotated_bitmap_led_matrix_render verification failed");
        $finish;
    end

    task automatic flag_led_error(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        errors++;
    endtask

    // deg in 0..359, result scaled by 2^14
    function automatic longint sine_q14(input int deg);
        int   k;
        logic neg;
        neg = deg >= 180;
        if (deg < 90) k = deg;
        else if (deg < 180) k = 180 - deg;
        else if (deg < 270) k = deg - 180;
        else k = 360 - deg;
        return neg ? -longint'(SINE_Q14[k]) : longint'(SINE_Q14[k]);
    endfunction

    // n / 2^15 to nearest, ties away from zero
    function automatic longint to_pixel(input longint n);
        if (n >= 0) return (n + ONE) >>> 15;
        return -((-n + ONE) >>> 15);
    endfunction

    task automatic render_frame(input logic signed [8:0] angle, input logic [7:0] r,
                                input logic [7:0] g, input logic [7:0] b, input chk_t chk);
        int     a;
        int     x;
        int     y;
        longint c;
        longint s;
        longint dx2;
        longint dy2;
        longint sx;
        longint sy;
        logic   lit;
        a = int'(angle) % 360;
        if (a < 0) a += 360;
        s = sine_q14(a);
        c = sine_q14((a + 90) % 360);
        for (int i = 0; i < LEDS; i++) begin
            x   = i / ROWS;
            y   = (x % 2 == 0) ? i % ROWS : ROWS - 1 - i % ROWS;
            dx2 = longint'(2 * x - (COLS - 1));
            dy2 = longint'(2 * y - (ROWS - 1));
            sx  = to_pixel(dx2 * c + dy2 * s + longint'((COLS - 1) * ONE));
            sy  = to_pixel(dy2 * c - dx2 * s + longint'((ROWS - 1) * ONE));
            lit = 1'b0;
            if (sx >= 0 && sx < COLS && sy >= 0 && sy < ROWS)
                lit = shape_now[sy * COLS + sx];
            if (chk == ALL_LIT) lit = 1'b1;
            if (chk == ALL_DARK) lit = 1'b0;
            led_q.push_back('{6'(i), lit ? g : 8'd0, lit ? r : 8'd0, lit ? b : 8'd0,
                              i == LEDS - 1});
        end
    endtask

    task automatic load_shape(input logic [49:0] value);
        s_tvalid <= 1'b0;
        while (led_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        shape_now = value;
    endtask

    task automatic send_request(input logic signed [8:0] angle, input logic [7:0] r,
                                input logic [7:0] g, input logic [7:0] b, input chk_t chk);
        int gap;
        gap = (sent % 10 < 3) ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, b, g, r, angle};
        do @(posedge aclk); while (!s_tready);
        render_frame(angle, r, g, b, chk);
        sent++;
    endtask

    // result side: random stalls, one long hold-off so the input backs up
    initial begin
        int n;
        int hold;
        n = 0;
        wait (aresetn);
        forever begin
            if (n == 300) hold = 600;
            else if ((n / 100) % 3 == 0) hold = 0;
            else hold = $urandom_range(0, 18);
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            n++;
        end
    end

    always @(posedge aclk) begin
        led_t got;
        led_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[5:0], m_tdata[13:6], m_tdata[21:14], m_tdata[29:22], m_tlast};
            if (led_q.size() == 0) begin
                flag_led_error($sformatf("led item %0d with none expected", got.idx));
            end else begin
                want = led_q.pop_front();
                if (got.idx != want.idx)
                    flag_led_error($sformatf("led_index %0d, want %0d", got.idx, want.idx));
                if (got.g != want.g)
                    flag_led_error($sformatf("led %0d green %h, want %h", want.idx, got.g, want.g));
                if (got.r != want.r)
                    flag_led_error($sformatf("led %0d red %h, want %h", want.idx, got.r, want.r));
                if (got.b != want.b)
                    flag_led_error($sformatf("led %0d blue %h, want %h", want.idx, got.b, want.b));
                if (got.last != want.last)
                    flag_led_error($sformatf("led %0d tlast %b, want %b", want.idx, got.last,
                                             want.last));
            end
        end
    end

    initial begin
        logic [49:0]       mask;
        logic signed [8:0] angle;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[k]) begin
            if (plan[k].wr) load_shape(plan[k].mask);
            send_request(plan[k].angle, plan[k].r, plan[k].g, plan[k].b, plan[k].chk);
        end

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: mask = 50'({$urandom, $urandom});
                1: mask = SHAPE_FULL;
                2: mask = 50'({$urandom, $urandom} & {$urandom, $urandom});
                3: mask = 50'({$urandom, $urandom} | {$urandom, $urandom});
                4: mask = rbmr_pkg::MASK_RESET;
                default: mask = 50'({$urandom, $urandom});
            endcase
            load_shape(mask);
            for (int k = 0; k < 25; k++) begin
                if ($urandom_range(0, 5) == 0) angle = 9'($urandom_range(0, 3) * 90 - 180);
                else angle = 9'($urandom_range(0, 511));
                send_request(angle, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), BY_MODEL);
            end
        end

        s_tvalid <= 1'b0;
        while (led_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("rotated_bitmap_led_matrix_render verification clean");
        end else begin
            $display("rotated_bitmap_led_matrix_render verification failed");
        end
        $finish;
    end

endmodule

// File: rotated_bitmap_led_matrix_render.f
design/rbmr_pkg.sv
design/rotated_bitmap_led_matrix_render.sv
tb/rotated_bitmap_led_matrix_render_tb.sv
